>>> rtl/bvhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvhq_pkg: shared types and threshold tables
// Widths, default band count, threshold ROMs and the controller/datapath
// command and status structs of the band hysteresis quantiser.
// ----------------------------------------------------------------------------
package bvhq_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int BAND_W        = 4;
  localparam int OUT_TDATA_W   = 8;
  localparam int NUM_BANDS_DEF = 13;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // take a new sample, start from the held band (clamped)
    logic step_up;    // move working band up by one
    logic step_down;  // move working band down by one
    logic commit;     // write result word and update held band
  } bvhq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic can_up;     // below top and sample above up threshold
    logic can_down;   // above zero and sample below down threshold
    logic out_free;   // output register empty or being drained
  } bvhq_stat_t;

  // Up thresholds; words past the table read as full scale
  function automatic logic [SAMPLE_W-1:0] up_thr(input logic [BAND_W-1:0] band);
    logic [SAMPLE_W-1:0] thr;
    unique case (band)
      4'd0:    thr = 16'd2975;
      4'd1:    thr = 16'd8511;
      4'd2:    thr = 16'd13759;
      4'd3:    thr = 16'd18751;
      4'd4:    thr = 16'd23679;
      4'd5:    thr = 16'd29247;
      4'd6:    thr = 16'd34751;
      4'd7:    thr = 16'd38815;
      4'd8:    thr = 16'd43423;
      4'd9:    thr = 16'd49055;
      4'd10:   thr = 16'd54527;
      4'd11:   thr = 16'd59615;
      default: thr = 16'd65535;
    endcase
    return thr;
  endfunction

  // Down thresholds; words past the table read as full scale
  function automatic logic [SAMPLE_W-1:0] down_thr(input logic [BAND_W-1:0] band);
    logic [SAMPLE_W-1:0] thr;
    unique case (band)
      4'd0:    thr = 16'd0;
      4'd1:    thr = 16'd1983;
      4'd2:    thr = 16'd7327;
      4'd3:    thr = 16'd12799;
      4'd4:    thr = 16'd17727;
      4'd5:    thr = 16'd22719;
      4'd6:    thr = 16'd28031;
      4'd7:    thr = 16'd33727;
      4'd8:    thr = 16'd38143;
      4'd9:    thr = 16'd42335;
      4'd10:   thr = 16'd47903;
      4'd11:   thr = 16'd53471;
      4'd12:   thr = 16'd58623;
      default: thr = 16'd65535;
    endcase
    return thr;
  endfunction

endpackage

>>> rtl/bvhq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvhq_datapath: sample, working band, held band and output register
// Compares the sample against the up and down thresholds of the working
// band, steps the working band as the controller commands, and holds the result word until taken.
// ----------------------------------------------------------------------------
module bvhq_datapath #(
  parameter int NUM_BANDS = bvhq_pkg::NUM_BANDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [bvhq_pkg::SAMPLE_W-1:0]      sample,
  input  bvhq_pkg::bvhq_cmd_t                cmd,
  output bvhq_pkg::bvhq_stat_t               stat,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bvhq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam logic [bvhq_pkg::BAND_W-1:0] TOP = bvhq_pkg::BAND_W'(NUM_BANDS - 1);

  logic [bvhq_pkg::SAMPLE_W-1:0] sample_q;
  logic [bvhq_pkg::BAND_W-1:0]   band;      // working band
  logic [bvhq_pkg::BAND_W-1:0]   held_band; // band of the previous word
  logic [bvhq_pkg::BAND_W-1:0]   band_index;
  logic                          band_changed;
  logic                          display_blank;

  // Threshold compares for the working band
  always_comb begin
    stat.can_up   = (band < TOP) && (bvhq_pkg::up_thr(band) < sample_q);
    stat.can_down = (band != '0) && (sample_q < bvhq_pkg::down_thr(band));
    stat.out_free = !m_tvalid || m_tready;
  end

  // Sample and working band
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= sample;
      band     <= (held_band > TOP) ? TOP : held_band;
    end else if (cmd.step_up) begin
      band <= band + 1'b1;
    end else if (cmd.step_down) begin
      band <= band - 1'b1;
    end
  end

  // Held band and result payload
  always_ff @(posedge clk) begin
    if (rst) begin
      held_band <= '0;
    end else if (cmd.commit) begin
      held_band <= band;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      band_index    <= band;
      band_changed  <= (band != held_band);
      display_blank <= (band == '0);
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, display_blank, band_changed, band_index};

endmodule

>>> rtl/bvhq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvhq_ctrl: sequencing state machine
// Accepts a word, walks the band up then down one step a cycle, and commits
// the result once the output register is free.
// ----------------------------------------------------------------------------
module bvhq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  bvhq_pkg::bvhq_stat_t stat,
  output bvhq_pkg::bvhq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_COMMIT
  } state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE);

  // Commands decoded from state and status
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == ST_IDLE) && s_tvalid;
    cmd.step_up   = (state == ST_UP) && stat.can_up;
    cmd.step_down = (state == ST_DOWN) && stat.can_down;
    cmd.commit    = (state == ST_COMMIT) && stat.out_free;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_UP;
        end
        ST_UP: begin
          if (!stat.can_up) state <= ST_DOWN;
        end
        ST_DOWN: begin
          if (!stat.can_down) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/band_voltage_hysteresis_quantizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_voltage_hysteresis_quantizer_core: band selection with hysteresis
// Maps each converter sample to a band index, stepping through the up and
// down threshold tables so that the band only moves across a dead zone.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_*       in   16     sample
// m_*       out  8      band_index[3:0], band_changed[4], display_blank[5]
//
// After its sample is taken, the working band steps up while the sample is
// above the up threshold, then down while it is below the down threshold; the
// result word is committed once the output register is free, and the next
// sample is taken after that commit. The threshold compare walks one band per cycle.
// Synchronous reset clears the held band to 0 and empties the output register.
// A new word is taken while a finished result waits; the commit of the next
// result waits until the output register is drained.
// ----------------------------------------------------------------------------
module band_voltage_hysteresis_quantizer_core #(
  parameter int NUM_BANDS = bvhq_pkg::NUM_BANDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bvhq_pkg::SAMPLE_W-1:0]    s_tdata,  // [15:0] sample
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bvhq_pkg::OUT_TDATA_W-1:0] m_tdata   // [3:0] band_index,
                                                     // [4] band_changed,
                                                     // [5] display_blank
);

  bvhq_pkg::bvhq_cmd_t  cmd;
  bvhq_pkg::bvhq_stat_t stat;

  bvhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bvhq_datapath #(
    .NUM_BANDS (NUM_BANDS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .sample   (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
